### hw/rtl/refcounted_palette_bank_allocator_assert.svh
// Assertion macros used by the palette bank allocator RTL.
`ifndef REFCOUNTED_PALETTE_BANK_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PALETTE_BANK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define RPBA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("palette bank allocator check failed");

// Next-cycle implication, clocked on clk and held off during reset.
`define RPBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("palette bank allocator check failed");

`endif

### hw/rtl/rpba_pkg.sv
// Package with the constants and codes of the palette bank allocator.
package rpba_pkg;

    // Field widths of the transaction ports.
    localparam int OPCODE_W = 1;
    localparam int SHEET_W  = 7;
    localparam int BIDX_W   = 3;
    localparam int BANK_W   = 4;
    localparam int USERS_W  = 5;

    // Configuration port geometry.
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 1'b1;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_BASE_BANK = 1'b0;

    typedef logic [BANK_W-1:0] abs_bank_t;

endpackage

### hw/rtl/rpba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module rpba_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/refcounted_palette_bank_allocator.sv
// Reference-counted palette bank allocator: sheet map in RAM, bank user counts.
//
//  Channel   | Direction | Handshake            | Payload
//  ----------+-----------+----------------------+------------------------------------------
//  request   | in        | start high, busy low | opcode, sheet_index, bank_index
//  result    | out       | done, one cycle      | bank, load_palette, fell_back,
//            |           |                      | users_after, sheet_released
//  config    | in/out    | APB, pready tied     | base_bank at byte address 0
//
// Each transaction reads the sheet map RAM on acceptance and then updates the map
// and the bank count in the update cycle. The result appears with done in the cycle
// after that, when the next transaction may already be accepted.
// Reset clears the map valid bits and all bank counts at once; no clearing pass.
// The receiver cannot stall results; busy is high only in the update cycle.

`include "refcounted_palette_bank_allocator_assert.svh"

module refcounted_palette_bank_allocator #(
    parameter int NUM_SHEETS = 128,
    parameter int NUM_BANKS  = 8,
    parameter int MAX_USERS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel
    input  logic                            start,
    output logic                            busy,
    input  logic [rpba_pkg::OPCODE_W-1:0]   opcode,
    input  logic [rpba_pkg::SHEET_W-1:0]    sheet_index,
    input  logic [rpba_pkg::BIDX_W-1:0]     bank_index,
    // Result channel
    output logic                            done,
    output logic [rpba_pkg::BANK_W-1:0]     bank,
    output logic                            load_palette,
    output logic                            fell_back,
    output logic [rpba_pkg::USERS_W-1:0]    users_after,
    output logic                            sheet_released,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpba_pkg::PADDR_W-1:0]    paddr,
    input  logic [rpba_pkg::PDATA_W-1:0]    pwdata,
    output logic [rpba_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    import rpba_pkg::*;

    localparam int SHEET_AW = (NUM_SHEETS > 1) ? $clog2(NUM_SHEETS) : 1;
    localparam int POOL_W   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int CNT_W    = $clog2(MAX_USERS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_USERS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Control and configuration state
    logic                   state_reg;
    logic                   state_next;
    abs_bank_t              base_bank_reg;
    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   cfg_idx;

    // Latched request
    logic [OPCODE_W-1:0]    op_reg;
    logic [SHEET_W-1:0]     sheet_reg;
    logic [BIDX_W-1:0]      bidx_reg;

    // Sheet map and bank counts
    logic [NUM_SHEETS-1:0]  map_valid_reg;
    logic [CNT_W-1:0]       users_reg [NUM_BANKS];
    logic [NUM_BANKS-1:0]   free_reg;
    logic [POOL_W-1:0]      map_rdata;
    logic                   map_we;

    // Result registers
    logic                   done_reg;
    abs_bank_t              bank_reg;
    logic                   load_reg;
    logic                   fb_reg;
    logic [USERS_W-1:0]     users_out_reg;
    logic                   rel_reg;

    // Datapath of the update cycle
    logic                   exec;
    logic                   accept;
    logic                   is_rel;
    logic [8:0]             sheet_ext;
    logic [8:0]             in_sheet_ext;
    logic [SHEET_AW-1:0]    sheet_addr;
    logic [SHEET_AW-1:0]    in_sheet_addr;
    logic [BANK_W-1:0]      bidx_ext;
    logic                   sheet_ok;
    logic                   bidx_ok;
    logic                   hit;
    logic                   free_any;
    logic [POOL_W-1:0]      free_idx;
    logic                   acq_new;
    logic [POOL_W-1:0]      acq_pool;
    logic [POOL_W-1:0]      sel_pool;
    logic [CNT_W-1:0]       cnt_cur;
    logic [CNT_W-1:0]       cnt_new;
    logic [15:0]            cnt_wide;
    logic                   cnt_we;
    logic                   rel_clear;
    abs_bank_t              bank_next;
    logic [USERS_W-1:0]     users_next;

    // Configuration port: a single register, no wait states.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready && (cfg_idx == REG_BASE_BANK);
    assign prdata  = (cfg_idx == REG_BASE_BANK) ? PDATA_W'(base_bank_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_bank_reg <= '0;
        end
        else if (cfg_wr)
        begin
            base_bank_reg <= pwdata[BANK_W-1:0];
        end
    end

    // Sequencer: idle until a request, then the update state.
    assign exec   = (state_reg == ST_EXEC);
    assign busy   = exec;
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the request fields on acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            sheet_reg <= sheet_index;
            bidx_reg  <= bank_index;
        end
    end

    // Address and range decoding.
    assign in_sheet_ext  = 9'(sheet_index);
    assign in_sheet_addr = in_sheet_ext[SHEET_AW-1:0];
    assign sheet_ext     = 9'(sheet_reg);
    assign sheet_addr    = sheet_ext[SHEET_AW-1:0];
    assign bidx_ext      = BANK_W'(bidx_reg);
    assign sheet_ok      = sheet_ext < 9'(NUM_SHEETS);
    assign bidx_ok       = bidx_ext < BANK_W'(NUM_BANKS);
    assign is_rel        = (op_reg == OP_RELEASE);

    // Sheet map RAM, read at acceptance and written in the update cycle.
    rpba_ram #(
        .WIDTH (POOL_W),
        .DEPTH (NUM_SHEETS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (sheet_addr),
        .wdata (free_idx),
        .raddr (in_sheet_addr),
        .rdata (map_rdata)
    );

    // Lowest bank that has no users.
    always_comb
    begin
        free_any = |free_reg;
        free_idx = '0;
        for (int i = NUM_BANKS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_idx = POOL_W'(i);
            end
        end
    end

    // Bank choice for acquire: mapped bank, else a free one, else pool bank zero.
    assign hit      = sheet_ok && map_valid_reg[sheet_addr];
    assign acq_new  = !hit && sheet_ok && free_any;
    assign acq_pool = hit ? map_rdata : (acq_new ? free_idx : '0);
    assign sel_pool = is_rel ? bidx_ext[POOL_W-1:0] : acq_pool;
    assign cnt_cur  = users_reg[sel_pool];

    // Count update: saturating increment on acquire, floored decrement on release.
    always_comb
    begin
        if (is_rel)
        begin
            cnt_new = (cnt_cur != '0) ? cnt_cur - 1'b1 : '0;
        end
        else
        begin
            cnt_new = (cnt_cur < CNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
        end
    end

    assign cnt_we    = exec && (!is_rel || bidx_ok);
    assign rel_clear = is_rel && bidx_ok && (cnt_new == '0) && sheet_ok;
    assign map_we    = exec && !is_rel && acq_new;

    // Map valid bits, bank counts and the free vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
            free_reg      <= '1;
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                users_reg[i] <= '0;
            end
        end
        else
        begin
            if (map_we)
            begin
                map_valid_reg[sheet_addr] <= 1'b1;
            end
            else if (exec && rel_clear)
            begin
                map_valid_reg[sheet_addr] <= 1'b0;
            end
            if (cnt_we)
            begin
                users_reg[sel_pool] <= cnt_new;
                free_reg[sel_pool]  <= (cnt_new == '0);
            end
        end
    end

    // Result fields.
    assign cnt_wide   = 16'(cnt_new);
    assign bank_next  = base_bank_reg + (is_rel ? bidx_ext : BANK_W'(acq_pool));
    assign users_next = (is_rel && !bidx_ok) ? '0 : cnt_wide[USERS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            bank_reg      <= bank_next;
            load_reg      <= !is_rel && acq_new;
            fb_reg        <= !is_rel && !hit && !acq_new;
            users_out_reg <= users_next;
            rel_reg       <= rel_clear;
        end
    end

    assign done           = done_reg;
    assign bank           = bank_reg;
    assign load_palette   = load_reg;
    assign fell_back      = fb_reg;
    assign users_after    = users_out_reg;
    assign sheet_released = rel_reg;

    // Checks on sequencing and on the result fields.
    `RPBA_ASSERT_IMPL(a_done_follows_accept, start && !busy, ##2 done)
    `RPBA_ASSERT_NEXT(a_busy_one_cycle, busy, !busy)
    `RPBA_ASSERT_IMPL(a_new_map_one_user, done && load_palette, users_after == 5'd1)
    `RPBA_ASSERT_IMPL(a_release_at_zero, done && sheet_released, users_after == 5'd0)

endmodule

### tb/rpba_checker.sv
// Checker that predicts the palette bank allocator's results and compares them.
module rpba_checker
    import rpba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [OPCODE_W-1:0]   opcode,
    input  logic [SHEET_W-1:0]    sheet_index,
    input  logic [BIDX_W-1:0]     bank_index,
    input  logic                  done,
    input  logic [BANK_W-1:0]     bank,
    input  logic                  load_palette,
    input  logic                  fell_back,
    input  logic [USERS_W-1:0]    users_after,
    input  logic                  sheet_released,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    input  logic [PDATA_W-1:0]    prdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending,
    output int                    checked,
    output int                    fallbacks,
    output int                    saturations
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SHEETS = 128;
    localparam int NUM_BANKS  = 8;
    localparam int MAX_USERS  = 16;

    typedef struct packed {
        logic [BANK_W-1:0]  bank;
        logic               load;
        logic               fb;
        logic [USERS_W-1:0] users;
        logic               rel;
    } grant_t;

    // Model state: sheet map, per-bank user counts and the base bank register.
    logic               map_valid [NUM_SHEETS];
    logic [BIDX_W-1:0]  map_pool  [NUM_SHEETS];
    int unsigned        pool_users [NUM_BANKS];
    logic [BANK_W-1:0]  base_bank_q;

    grant_t grants_due [$];
    int     errors;
    int     n_checked;
    int     n_fallbacks;
    int     n_saturations;

    // Works out the result of one transaction and updates the model state.
    function automatic grant_t predict_grant(logic [OPCODE_W-1:0] op,
                                             logic [SHEET_W-1:0] sheet,
                                             logic [BIDX_W-1:0] bidx);
        grant_t g;
        int     pool;
        bit     found;
        bit     sheet_ok;
        g        = '0;
        pool     = 0;
        found    = 1'b0;
        sheet_ok = int'(sheet) < NUM_SHEETS;
        if (op == OP_ACQUIRE) begin
            if (sheet_ok && map_valid[sheet] && int'(map_pool[sheet]) < NUM_BANKS) begin
                pool = int'(map_pool[sheet]);
            end
            else begin
                // Scan downwards so that the lowest idle bank wins.
                if (sheet_ok) begin
                    for (int i = NUM_BANKS - 1; i >= 0; i--) begin
                        if (pool_users[i] == 0) begin
                            pool  = i;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    map_valid[sheet] = 1'b1;
                    map_pool[sheet]  = BIDX_W'(pool);
                    g.load           = 1'b1;
                end
                else begin
                    pool = 0;
                    g.fb = 1'b1;
                    n_fallbacks++;
                end
            end
            if (pool_users[pool] < MAX_USERS)
                pool_users[pool]++;
            else
                n_saturations++;
            g.bank  = BANK_W'(int'(base_bank_q) + pool);
            g.users = USERS_W'(pool_users[pool]);
        end
        else if (int'(bidx) >= NUM_BANKS) begin
            g.bank = BANK_W'(int'(base_bank_q) + int'(bidx));
        end
        else begin
            if (pool_users[bidx] > 0)
                pool_users[bidx]--;
            if (pool_users[bidx] == 0 && sheet_ok) begin
                map_valid[sheet] = 1'b0;
                map_pool[sheet]  = '0;
                g.rel            = 1'b1;
            end
            g.bank  = BANK_W'(int'(base_bank_q) + int'(bidx));
            g.users = USERS_W'(pool_users[bidx]);
        end
        return g;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Watch the configuration port, the result strobe and the request channel.
    always @(posedge clk or negedge rst_n) begin
        grant_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_SHEETS; i++) begin
                map_valid[i] = 1'b0;
                map_pool[i]  = '0;
            end
            for (int i = 0; i < NUM_BANKS; i++)
                pool_users[i] = 0;
            base_bank_q   = '0;
            grants_due.delete();
            errors        = 0;
            n_checked     = 0;
            n_fallbacks   = 0;
            n_saturations = 0;
        end
        else begin
            // Register writes and read-back.
            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_BASE_BANK) begin
                if (pwrite)
                    base_bank_q = pwdata[BANK_W-1:0];
                else
                    check_field("prdata", PDATA_W'(base_bank_q), prdata);
            end

            // Result transaction against the oldest expectation.
            if (done) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: result with no transaction outstanding, expected none actual bank %0d",
                             $time, bank);
                    errors++;
                end
                else begin
                    want = grants_due.pop_front();
                    check_field("bank", want.bank, bank);
                    check_field("load_palette", want.load, load_palette);
                    check_field("fell_back", want.fb, fell_back);
                    check_field("users_after", want.users, users_after);
                    check_field("sheet_released", want.rel, sheet_released);
                    n_checked++;
                end
            end

            // Accepted request transaction.
            if (start && !busy)
                grants_due.push_back(predict_grant(opcode, sheet_index, bank_index));
        end
        fail_count  <= errors;
        pending     <= grants_due.size();
        checked     <= n_checked;
        fallbacks   <= n_fallbacks;
        saturations <= n_saturations;
    end

endmodule

### tb/refcounted_palette_bank_allocator_test.sv
// Top of the palette bank allocator testbench: clock, reset, stimulus and verdict.
module refcounted_palette_bank_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rpba_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 300;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic [OPCODE_W-1:0]  opcode      = OP_ACQUIRE;
    logic [SHEET_W-1:0]   sheet_index = '0;
    logic [BIDX_W-1:0]    bank_index  = '0;
    logic                 done;
    logic [BANK_W-1:0]    bank;
    logic                 load_palette;
    logic                 fell_back;
    logic [USERS_W-1:0]   users_after;
    logic                 sheet_released;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int checked;
    int fallbacks;
    int saturations;
    int cycle_count = 0;

    refcounted_palette_bank_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .opcode(opcode), .sheet_index(sheet_index), .bank_index(bank_index),
        .done(done), .bank(bank), .load_palette(load_palette), .fell_back(fell_back),
        .users_after(users_after), .sheet_released(sheet_released),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rpba_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .opcode(opcode), .sheet_index(sheet_index), .bank_index(bank_index),
        .done(done), .bank(bank), .load_palette(load_palette), .fell_back(fell_back),
        .users_after(users_after), .sheet_released(sheet_released),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .pending(pending), .checked(checked),
        .fallbacks(fallbacks), .saturations(saturations)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d transactions outstanding",
                     cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [OPCODE_W-1:0] op, input int sheet,
                                input int bidx);
        start       <= 1'b1;
        opcode      <= op;
        sheet_index <= SHEET_W'(sheet);
        bank_index  <= BIDX_W'(bidx);
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Write the base bank register and read it straight back.
    task automatic program_base(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BASE_BANK, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random request; sheets mostly come from a small hot set.
    task automatic random_request(input int acquire_pct);
        logic [OPCODE_W-1:0] op;
        int                  sheet;
        op    = ($urandom_range(0, 99) < acquire_pct) ? OP_ACQUIRE : OP_RELEASE;
        sheet = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 15) : $urandom_range(0, 127);
        send_request(op, sheet, $urandom_range(0, 7));
    endtask

    initial
    begin
        int  n;
        int  hot_sheet;
        int  base_setting;
        bit  idle_on;
        bit  last_stretch;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the base bank at its reset value.
        send_request(OP_RELEASE, 9, 3);      // release of an idle bank
        send_request(OP_ACQUIRE, 0, 7);      // first mapping, bank index ignored
        send_request(OP_ACQUIRE, 127, 0);    // highest sheet
        send_request(OP_ACQUIRE, 0, 0);      // already mapped
        send_request(OP_RELEASE, 0, 0);
        send_request(OP_RELEASE, 0, 0);      // count reaches zero, mapping cleared
        for (int s = 10; s <= 16; s++)
        begin
            send_request(OP_ACQUIRE, s, 0);  // fill every bank
        end
        send_request(OP_ACQUIRE, 20, 0);     // no free bank: fall back to the base
        send_request(OP_ACQUIRE, 127, 0);
        send_request(OP_RELEASE, 99, 5);     // sheet not on the bank being released
        send_request(OP_ACQUIRE, 14, 0);     // stale mapping onto an idle bank
        send_request(OP_RELEASE, 127, 2);    // clears a mapping held on another bank
        send_request(OP_ACQUIRE, 127, 0);
        send_request(OP_RELEASE, 127, 7);
        send_request(OP_RELEASE, 0, 7);

        // Random phases, each programming a base bank, extremes included.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0:       base_setting = 15;
                2:       base_setting = 0;
                4:       base_setting = 7;
                5:       base_setting = 15;
                default: base_setting = $urandom_range(0, 15);
            endcase
            program_base(base_setting);
            n       = 0;
            idle_on = 1'b1;
            while (n < PHASE_ITEMS)
            begin
                last_stretch = (ph == PHASES - 1) && (n >= PHASE_ITEMS / 2);
                if (n % 60 == 0)
                begin
                    idle_on = !last_stretch && ($urandom_range(0, 3) != 0);
                end
                if (ph == 2 && n == PHASE_ITEMS / 2)
                begin
                    drain_results();
                end
                if (idle_on && !last_stretch && $urandom_range(0, 3) == 0)
                begin
                    idle_cycles($urandom_range(1, 8));
                end
                if ($urandom_range(0, 99) < 3)
                begin
                    // A run of acquires on one sheet drives its bank to saturation.
                    hot_sheet = $urandom_range(0, 15);
                    repeat (18) send_request(OP_ACQUIRE, hot_sheet, $urandom_range(0, 7));
                    n += 18;
                end
                else
                begin
                    random_request((ph % 2 == 0) ? 65 : 45);
                    n++;
                end
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("covered %0d results over %0d base bank settings, with %0d fallbacks",
                 checked, PHASES + 1, fallbacks);
        $display("and %0d acquires on a saturated bank, %0d mismatches", saturations, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
